// ===== hw/rtl/hgpe_pkg.sv =====
package hgpe_pkg;

  // input transaction: one led colour
  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] sat_byte;
    logic [7:0] level;
  } hsv_t;

  // output transaction: one bit slot of the serial word
  typedef struct packed {
    logic [15:0] pulse_width;
    logic        last_bit;
  } pulse_t;

  // colour word in wire order, green first
  typedef struct packed {
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } grb_t;

  localparam int unsigned WordBits = 24;
  localparam int unsigned CntW     = $clog2(WordBits);

  localparam logic [8:0] HueMax    = 9'd359;
  localparam logic [7:0] GraySat   = 8'd255;
  localparam logic [5:0] SectorDeg = 6'd60;

  // floor(x / 60) = (x * recip) >> shift, exact over the ranges used here
  localparam logic [10:0] HueRecip  = 11'd1093;   // shift 16, x <= 359
  localparam logic [14:0] RampRecip = 15'd17477;  // shift 20, x <= 15300

  localparam int unsigned CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] CfgWidthOne  = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWidthZero = 8'd1;

endpackage

// ===== hw/rtl/hgpe_color_pipe.sv =====
module hgpe_color_pipe import hgpe_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  hsv_t hsv_i,
  output logic valid_o,
  input  logic ready_i,
  output grb_t grb_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v4_q;

  // stage 1: clamp, sector, base
  logic [8:0]  hue_c;
  logic [19:0] hue_prod;
  logic [15:0] sv_prod;
  logic [8:0]  hue1_q;
  logic [2:0]  sec1_q;
  logic [7:0]  base1_q, lvl1_q;
  logic        gray1_q;

  assign hue_c    = (hsv_i.hue > HueMax) ? HueMax : hsv_i.hue;
  assign hue_prod = 20'(hue_c) * 20'(HueRecip);
  assign sv_prod  = 16'(hsv_i.sat_byte) * 16'(hsv_i.level);

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      hue1_q  <= hue_c;
      sec1_q  <= hue_prod[18:16];
      base1_q <= sv_prod[15:8];
      lvl1_q  <= hsv_i.level;
      gray1_q <= (hsv_i.sat_byte == GraySat);
    end
  end

  // stage 2: offset within sector, ramp direction, span
  logic [8:0] sec_deg;
  logic [5:0] f2;
  logic [5:0] x2_q;
  logic [7:0] diff2_q, base2_q, lvl2_q;
  logic [2:0] sec2_q;
  logic       gray2_q;

  assign sec_deg = 9'(sec1_q) * 9'(SectorDeg);
  assign f2      = 6'(hue1_q - sec_deg);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      x2_q    <= sec1_q[0] ? (SectorDeg - f2) : f2;
      diff2_q <= lvl1_q - base1_q;
      base2_q <= base1_q;
      lvl2_q  <= lvl1_q;
      sec2_q  <= sec1_q;
      gray2_q <= gray1_q;
    end
  end

  // stage 3: span times position
  logic [13:0] prod3_q;
  logic [7:0]  base3_q, lvl3_q;
  logic [2:0]  sec3_q;
  logic        gray3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      prod3_q <= 14'(diff2_q) * 14'(x2_q);
      base3_q <= base2_q;
      lvl3_q  <= lvl2_q;
      sec3_q  <= sec2_q;
      gray3_q <= gray2_q;
    end
  end

  // stage 4: divide by 60, add floor, place channels
  logic [28:0] q_prod;
  logic [7:0]  ramp;
  grb_t        grb_d, grb_q;

  assign q_prod = 29'(prod3_q) * 29'(RampRecip);
  assign ramp   = q_prod[27:20] + base3_q;

  always_comb begin
    grb_d = '{g: lvl3_q, r: lvl3_q, b: lvl3_q};
    if (!gray3_q) begin
      case (sec3_q)
        3'd0:    grb_d = '{g: ramp,    r: lvl3_q,  b: base3_q};
        3'd1:    grb_d = '{g: lvl3_q,  r: ramp,    b: base3_q};
        3'd2:    grb_d = '{g: lvl3_q,  r: base3_q, b: ramp};
        3'd3:    grb_d = '{g: ramp,    r: base3_q, b: lvl3_q};
        3'd4:    grb_d = '{g: base3_q, r: ramp,    b: lvl3_q};
        default: grb_d = '{g: base3_q, r: lvl3_q,  b: ramp};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      grb_q <= grb_d;
    end
  end

  assign grb_o = grb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

endmodule

// ===== hw/rtl/hsv_to_grb_pulse_encoder.sv =====
// hsv to grb pulse-width encoder for a serial led strip
//
// input channel (in_valid_i / in_ready_o / in_data_i): one transaction per
// led colour, hue in degrees (above 359 saturates to 359), s byte, level v
// output channel (out_valid_o / out_ready_i / out_data_o): 24 transactions per
// colour, the timer compare value for each bit of the g,r,b word, msb first,
// last_bit set on the 24th
// config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
// index 0 sets the width for a one bit, index 1 the width for a zero bit,
// other indexes are dropped; always ready, write only while idle
// the first bit becomes valid once the colour has moved through the pipe
// (three more colour stages after the input stage, then the shifter loads)
// the bit shifter sets the colour rate; it emits one bit per cycle while
// out_ready_i is high, and the next word loads in the cycle the last bit leaves, so
// bits stream without gaps while colours keep coming
// the four-stage colour pipe takes colours every cycle until it is full
// reset clears all valid flags and both widths to zero
// a stalled receiver freezes the shifter; the colour pipe fills up and then
// drops in_ready_o, nothing is lost or repeated
module hsv_to_grb_pulse_encoder import hgpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsv_t               in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pulse_t             out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  // configuration registers
  logic [15:0] width_one_q, width_zero_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_one_q  <= '0;
      width_zero_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgWidthOne:  width_one_q  <= cfg_data_i;
        CfgWidthZero: width_zero_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // colour conversion pipeline
  logic pipe_valid, pipe_ready;
  grb_t pipe_grb;

  hgpe_color_pipe u_color_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .hsv_i   (in_data_i),
    .valid_o (pipe_valid),
    .ready_i (pipe_ready),
    .grb_o   (pipe_grb)
  );

  // bit shifter, doubles as the output register
  logic [WordBits-1:0] word_q;
  logic [CntW-1:0]     cnt_q;
  logic                ser_valid_q;
  logic                last, out_fire, load;

  assign last       = (cnt_q == CntW'(WordBits - 1));
  assign out_fire   = ser_valid_q && out_ready_i;
  // free when empty or when the final bit leaves this cycle
  assign pipe_ready = !ser_valid_q || (out_ready_i && last);
  assign load       = pipe_valid && pipe_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else if (load) begin
      ser_valid_q <= 1'b1;
      cnt_q       <= '0;
    end else if (out_fire) begin
      ser_valid_q <= !last;
      cnt_q       <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= pipe_grb;
    end else if (out_fire) begin
      word_q <= {word_q[WordBits-2:0], 1'b0};
    end
  end

  assign out_valid_o            = ser_valid_q;
  assign out_data_o.pulse_width = word_q[WordBits-1] ? width_one_q : width_zero_q;
  assign out_data_o.last_bit    = last;

  // a bit taken mid-word moves to the next bit and keeps the word alive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last) |=> (out_valid_o && cnt_q == $past(cnt_q) + 1'b1))
    else $error("bit counter did not advance");

  // the final bit with nothing queued empties the shifter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && last && !pipe_valid) |=> !out_valid_o)
    else $error("word repeated after last bit");

  // a new word always starts at its first bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_o && cnt_q == '0 && word_q == $past(pipe_grb)))
    else $error("word load failed");

  // stalled receiver freezes the shifter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_valid_q && !out_ready_i) |=> ($stable(word_q) && $stable(cnt_q)))
    else $error("shifter moved during stall");

endmodule
